FILE: sv/adsr_pkg.sv
// shared types, constants and register indexes for the adsr envelope gain block
package adsr_pkg;

  // level format, q1.16 with 65536 as full scale
  localparam int unsigned LVL_W = 17;
  localparam int unsigned CNT_W = 24;
  localparam int unsigned SMP_W = 16;
  localparam logic [LVL_W-1:0] FULL_SCALE = 17'h10000;
  localparam logic [LVL_W-1:0] ZERO_LEVEL = 17'h00000;

  // passes one sample may need to walk from attack through to idle
  localparam int unsigned NUM_PASSES = 5;

  // register reset values
  localparam logic [LVL_W-1:0] RST_ATTACK_STEP   = 17'd64;
  localparam logic [LVL_W-1:0] RST_DECAY_STEP    = 17'd64;
  localparam logic [LVL_W-1:0] RST_SUSTAIN_LEVEL = 17'd32768;
  localparam logic [CNT_W-1:0] RST_SUSTAIN_SMP   = 24'd48000;
  localparam logic [LVL_W-1:0] RST_RELEASE_STEP  = 17'd64;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_ATTACK  = 3'd1,
    PH_DECAY   = 3'd2,
    PH_SUSTAIN = 3'd3,
    PH_RELEASE = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    OP_SAMPLE   = 2'd0,
    OP_NOTE_ON  = 2'd1,
    OP_NOTE_OFF = 2'd2
  } opcode_t;

  typedef enum logic [2:0] {
    CFG_ATTACK_STEP   = 3'd0,
    CFG_DECAY_STEP    = 3'd1,
    CFG_SUSTAIN_LEVEL = 3'd2,
    CFG_SUSTAIN_SMP   = 3'd3,
    CFG_RELEASE_STEP  = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic [LVL_W-1:0] attack_step;
    logic [LVL_W-1:0] decay_step;
    logic [LVL_W-1:0] sustain_level;
    logic [CNT_W-1:0] sustain_samples;
    logic [LVL_W-1:0] release_step;
  } cfg_t;

  typedef struct packed {
    logic [LVL_W-1:0] level;
    phase_t           phase;
  } env_res_t;

endpackage

FILE: sv/adsr_cfg.sv
// configuration register bank of the envelope generator
module adsr_cfg import adsr_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [2:0]       cfg_index,
  input  logic [CNT_W-1:0] cfg_wdata,
  output cfg_t             cfg
);

  cfg_t cfg_r;

  // register writes, unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.attack_step     <= RST_ATTACK_STEP;
      cfg_r.decay_step      <= RST_DECAY_STEP;
      cfg_r.sustain_level   <= RST_SUSTAIN_LEVEL;
      cfg_r.sustain_samples <= RST_SUSTAIN_SMP;
      cfg_r.release_step    <= RST_RELEASE_STEP;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_ATTACK_STEP:   cfg_r.attack_step     <= cfg_wdata[LVL_W-1:0];
        CFG_DECAY_STEP:    cfg_r.decay_step      <= cfg_wdata[LVL_W-1:0];
        CFG_SUSTAIN_LEVEL: cfg_r.sustain_level   <= cfg_wdata[LVL_W-1:0];
        CFG_SUSTAIN_SMP:   cfg_r.sustain_samples <= cfg_wdata;
        CFG_RELEASE_STEP:  cfg_r.release_step    <= cfg_wdata[LVL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

FILE: sv/adsr_env.sv
// envelope state and the per-request phase and level update
module adsr_env import adsr_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     upd_en,
  input  opcode_t  opcode,
  input  cfg_t     cfg,
  output env_res_t res
);

  phase_t           phase_r, phase_nxt;
  logic [LVL_W-1:0] level_r, level_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  phase_t            ph;
  logic signed [18:0] lvl;
  logic [CNT_W-1:0]  cnt;
  logic              done;
  logic [LVL_W-1:0]  sl;
  logic signed [18:0] sl_s;
  logic signed [18:0] full_s;

  // sustain level is capped at full scale
  assign sl     = (cfg.sustain_level > FULL_SCALE) ? FULL_SCALE : cfg.sustain_level;
  assign sl_s   = $signed({2'b00, sl});
  assign full_s = $signed({2'b00, FULL_SCALE});

  // walk the phases for one sample, redoing it on each boundary crossing
  always_comb begin
    ph   = phase_r;
    lvl  = $signed({2'b00, level_r});
    cnt  = count_r;
    done = 1'b0;
    for (int i = 0; i < NUM_PASSES; i++) begin
      if (!done) begin
        unique case (ph)
          PH_ATTACK: begin
            if (cfg.attack_step == ZERO_LEVEL) begin
              ph = PH_DECAY;
            end else begin
              lvl = lvl + $signed({2'b00, cfg.attack_step});
              if (lvl > full_s) begin
                lvl = full_s;
                ph  = PH_DECAY;
              end else begin
                done = 1'b1;
              end
            end
          end
          PH_DECAY: begin
            if (cfg.decay_step == ZERO_LEVEL) begin
              cnt = '0;
              ph  = PH_SUSTAIN;
            end else begin
              lvl = lvl - $signed({2'b00, cfg.decay_step});
              if (lvl < sl_s) begin
                lvl = sl_s;
                cnt = '0;
                ph  = PH_SUSTAIN;
              end else begin
                done = 1'b1;
              end
            end
          end
          PH_SUSTAIN: begin
            lvl = sl_s;
            if (cnt >= cfg.sustain_samples) begin
              ph = PH_RELEASE;
            end else begin
              cnt  = cnt + 1'b1;
              done = 1'b1;
            end
          end
          PH_RELEASE: begin
            if (cfg.release_step == ZERO_LEVEL) begin
              ph = PH_IDLE;
            end else begin
              lvl = lvl - $signed({2'b00, cfg.release_step});
              if (lvl < 0) begin
                lvl = '0;
                ph  = PH_IDLE;
              end else begin
                done = 1'b1;
              end
            end
          end
          default: begin
            ph   = PH_IDLE;
            lvl  = '0;
            done = 1'b1;
          end
        endcase
      end
    end
  end

  assign res.level = lvl[LVL_W-1:0];
  assign res.phase = ph;

  // next state per opcode, unused opcode leaves everything as is
  always_comb begin
    phase_nxt = phase_r;
    level_nxt = level_r;
    count_nxt = count_r;
    if (upd_en) begin
      unique case (opcode)
        OP_SAMPLE: begin
          phase_nxt = ph;
          level_nxt = lvl[LVL_W-1:0];
          count_nxt = cnt;
        end
        OP_NOTE_ON: begin
          phase_nxt = PH_ATTACK;
        end
        OP_NOTE_OFF: begin
          if (phase_r != PH_IDLE) begin
            phase_nxt = PH_RELEASE;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // envelope state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      level_r <= ZERO_LEVEL;
      count_r <= '0;
    end else begin
      phase_r <= phase_nxt;
      level_r <= level_nxt;
      count_r <= count_nxt;
    end
  end

  // level stays within full scale
  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    level_r <= FULL_SCALE)
    else $error("envelope level above full scale");

  // idle always holds a zero level
  a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_IDLE |-> level_r == ZERO_LEVEL)
    else $error("idle phase with nonzero level");

  // note on always lands in attack
  a_note_on: assert property (@(posedge clk) disable iff (!rst_n)
    upd_en && opcode == OP_NOTE_ON |=> phase_r == PH_ATTACK)
    else $error("note on did not start attack");

endmodule

FILE: sv/adsr_gain.sv
// gain stage: level times sample, then the result register
module adsr_gain import adsr_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    load,
  input  env_res_t                env,
  input  logic signed [SMP_W-1:0] sample,
  output logic                    ready,
  output logic                    out_tvalid,
  input  logic                    out_tready,
  output logic [23:0]             out_tdata
);

  logic                    s2_v_r;
  logic [LVL_W-1:0]        s2_level_r;
  logic signed [SMP_W-1:0] s2_sample_r;
  phase_t                  s2_phase_r;

  logic                    out_v_r;
  logic signed [SMP_W-1:0] out_sample_r;
  phase_t                  out_phase_r;

  logic                    out_free;
  logic                    s2_move;
  logic signed [33:0]      prod;

  assign out_free = !out_v_r || out_tready;
  assign s2_move  = s2_v_r && out_free;
  assign ready    = !s2_v_r || out_free;

  // signed product, arithmetic shift by 16 is the upper slice
  assign prod = $signed({1'b0, s2_level_r}) * s2_sample_r;

  // valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (ready) begin
        s2_v_r <= load;
      end
      if (out_free) begin
        out_v_r <= s2_v_r;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (ready && load) begin
      s2_level_r  <= env.level;
      s2_sample_r <= sample;
      s2_phase_r  <= env.phase;
    end
    if (s2_move) begin
      out_sample_r <= prod[31:16];
      out_phase_r  <= s2_phase_r;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {5'b00000, out_phase_r, out_sample_r};

  // a stalled result keeps the middle stage waiting
  a_s2_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s2_v_r && out_v_r && !out_tready |=> s2_v_r)
    else $error("middle stage lost a request under stall");

  // a result in idle is silent
  a_idle_silent: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_phase_r == PH_IDLE |-> out_sample_r == '0)
    else $error("nonzero sample in idle phase");

endmodule

FILE: sv/adsr_envelope_gain.sv
// adsr envelope gain top level: input register, envelope update, gain stage
// a sample result moves through input register, middle stage and result register
// throughput: one request per cycle unless out_tready stalls; the level update for
//   one sample, over all phase changes it crosses, is combinational into the state
// note on and note off requests update the state and give no result
// reset: synchronous active-low rst_n sets idle phase, zero level and count,
//   register defaults, and empties all stages
module adsr_envelope_gain import adsr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  // configuration writes
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_wdata,
  // input requests
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] sample_in
  input  logic [1:0]  in_tuser,   // [1:0] opcode
  // result requests
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // [15:0] sample_out, [18:16] phase_now, rest zero
);

  cfg_t                    cfg;
  env_res_t                env;
  logic                    s1_v_r;
  opcode_t                 s1_op_r;
  logic signed [SMP_W-1:0] s1_sample_r;
  logic                    s2_ready;
  logic                    s1_move;

  assign s1_move   = s1_v_r && s2_ready;
  assign in_tready = !s1_v_r || s2_ready;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_tready) begin
      s1_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_op_r     <= opcode_t'(in_tuser);
      s1_sample_r <= $signed(in_tdata);
    end
  end

  adsr_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  adsr_env u_env (
    .clk    (clk),
    .rst_n  (rst_n),
    .upd_en (s1_move),
    .opcode (s1_op_r),
    .cfg    (cfg),
    .res    (env)
  );

  // only audio samples move on to the gain stage
  adsr_gain u_gain (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (s1_move && s1_op_r == OP_SAMPLE),
    .env        (env),
    .sample     (s1_sample_r),
    .ready      (s2_ready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // a waiting input request is held until the gain stage takes it
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r && !s2_ready |=> s1_v_r && $stable(s1_op_r))
    else $error("input register dropped a request under stall");

endmodule

FILE: dv/testbench.sv
// self-checking testbench for the adsr envelope gain block, with its own envelope predictor
module testbench;
  import adsr_pkg::*;

  // opcode the block must ignore, no result and no state change
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int MAX_PASSES = 6;
  localparam int RANDOM_ROUNDS = 8;
  localparam int ROUND_REQUESTS = 180;

  typedef struct {
    logic [15:0] gain;
    phase_t      ph;
  } gain_res_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [23:0] cfg_wdata;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;

  // predictor copy of the registers and the envelope state
  cfg_t        regs;
  phase_t      env_ph;
  int          env_lvl;
  logic [23:0] hold_cnt;

  gain_res_t   gain_results_due[$];
  int          mismatch_count = 0;
  int          gap_pct = 0;
  int          stall_pct = 0;

  adsr_envelope_gain DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // run limit
  initial begin
    #4000000;
    $display("testbench failed");
    $finish;
  end

  // receiver stalls
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  function automatic void flag_mismatch(input string what);
    if (mismatch_count < 10) $display("mismatch: %s", what);
    mismatch_count++;
  endfunction

  // result checker, oldest expectation first
  always @(posedge clk) begin : check_out
    gain_res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (gain_results_due.size() == 0) begin
        flag_mismatch($sformatf("result %h with none expected", out_tdata));
      end else begin
        want = gain_results_due.pop_front();
        if (out_tdata[15:0] !== want.gain || out_tdata[18:16] !== want.ph ||
            out_tdata[23:19] !== '0) begin
          flag_mismatch($sformatf("got sample %h phase %0d pad %h, want sample %h phase %0d",
                                  out_tdata[15:0], out_tdata[18:16], out_tdata[23:19],
                                  want.gain, want.ph));
        end
      end
    end
  end

  function automatic void envelope_reset();
    regs.attack_step     = RST_ATTACK_STEP;
    regs.decay_step      = RST_DECAY_STEP;
    regs.sustain_level   = RST_SUSTAIN_LEVEL;
    regs.sustain_samples = RST_SUSTAIN_SMP;
    regs.release_step    = RST_RELEASE_STEP;
    env_ph   = PH_IDLE;
    env_lvl  = 0;
    hold_cnt = '0;
  endfunction

  // envelope predictor: steers the phase and queues the gain result of a sample
  function automatic void envelope_apply(input logic [1:0] op, input logic [15:0] smp);
    int        lvl;
    int        floor_lvl;
    int        n;
    bit        done;
    bit        silent;
    longint    prod;
    gain_res_t want;
    floor_lvl = (regs.sustain_level > FULL_SCALE) ? int'(FULL_SCALE)
                                                  : int'(regs.sustain_level);
    case (op)
      OP_NOTE_ON: env_ph = PH_ATTACK;
      OP_NOTE_OFF: if (env_ph != PH_IDLE) env_ph = PH_RELEASE;
      OP_SAMPLE: begin
        lvl = env_lvl;
        done = 1'b0;
        silent = 1'b0;
        // a sample crossing a boundary is redone under the next phase
        for (n = 0; n < MAX_PASSES && !done; n++) begin
          case (env_ph)
            PH_ATTACK: begin
              if (regs.attack_step == '0) begin
                env_ph = PH_DECAY;
              end else begin
                lvl += int'(regs.attack_step);
                if (lvl > int'(FULL_SCALE)) begin
                  lvl = int'(FULL_SCALE);
                  env_ph = PH_DECAY;
                end else begin
                  done = 1'b1;
                end
              end
            end
            PH_DECAY: begin
              if (regs.decay_step == '0) begin
                hold_cnt = '0;
                env_ph = PH_SUSTAIN;
              end else begin
                lvl -= int'(regs.decay_step);
                if (lvl < floor_lvl) begin
                  lvl = floor_lvl;
                  hold_cnt = '0;
                  env_ph = PH_SUSTAIN;
                end else begin
                  done = 1'b1;
                end
              end
            end
            PH_SUSTAIN: begin
              lvl = floor_lvl;
              if (hold_cnt >= regs.sustain_samples) begin
                env_ph = PH_RELEASE;
              end else begin
                hold_cnt = hold_cnt + 1'b1;
                done = 1'b1;
              end
            end
            PH_RELEASE: begin
              if (regs.release_step == '0) begin
                env_ph = PH_IDLE;
              end else begin
                lvl -= int'(regs.release_step);
                if (lvl < 0) begin
                  lvl = 0;
                  env_ph = PH_IDLE;
                end else begin
                  done = 1'b1;
                end
              end
            end
            default: begin
              env_ph = PH_IDLE;
              lvl = 0;
              silent = 1'b1;
              done = 1'b1;
            end
          endcase
        end
        env_lvl = lvl;
        // gain stage, arithmetic shift rounds toward minus infinity
        prod = longint'(signed'(smp)) * longint'(lvl);
        want.gain = silent ? 16'h0000 : 16'(prod >>> 16);
        want.ph = env_ph;
        gain_results_due.push_back(want);
      end
      default: ;
    endcase
  endfunction

  // one request on the input channel, valid kept high into the next request
  task automatic send_req(input logic [1:0] op, input logic [15:0] smp);
    while ($urandom_range(99) < gap_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= smp;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    envelope_apply(op, smp);
  endtask

  // sender holds off until every result is in and the pipe is empty
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (gain_results_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // writes all five registers, block must be idle
  task automatic program_regs(input cfg_t c);
    cfg_idx_t    idx_list[5];
    logic [23:0] val_list[5];
    int          k;
    idx_list = '{CFG_ATTACK_STEP, CFG_DECAY_STEP, CFG_SUSTAIN_LEVEL, CFG_SUSTAIN_SMP,
                 CFG_RELEASE_STEP};
    val_list = '{24'(c.attack_step), 24'(c.decay_step), 24'(c.sustain_level),
                 c.sustain_samples, 24'(c.release_step)};
    for (k = 0; k < 5; k++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx_list[k];
      cfg_wdata <= val_list[k];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    regs = c;
  endtask

  function automatic cfg_t regs_of(input int unsigned atk, input int unsigned dec,
                                   input int unsigned lvl, input int unsigned cnt,
                                   input int unsigned rel);
    cfg_t c;
    c.attack_step     = LVL_W'(atk);
    c.decay_step      = LVL_W'(dec);
    c.sustain_level   = LVL_W'(lvl);
    c.sustain_samples = CNT_W'(cnt);
    c.release_step    = LVL_W'(rel);
    return c;
  endfunction

  function automatic int unsigned rand_step();
    case ($urandom_range(15))
      0: return 0;
      1: return 65536;
      2: return $urandom_range(65537, 131071);
      3: return $urandom_range(1, 300);
      default: return $urandom_range(4000, 40000);
    endcase
  endfunction

  function automatic cfg_t rand_regs();
    int unsigned lvl;
    int unsigned cnt;
    case ($urandom_range(7))
      0: lvl = 0;
      1: lvl = 65536;
      2: lvl = $urandom_range(65537, 131071);
      default: lvl = $urandom_range(0, 65536);
    endcase
    case ($urandom_range(9))
      0: cnt = 0;
      1: cnt = $urandom_range(100, 16777215);
      default: cnt = $urandom_range(1, 10);
    endcase
    return regs_of(rand_step(), rand_step(), lvl, cnt, rand_step());
  endfunction

  function automatic logic [15:0] rand_sample();
    case ($urandom_range(7))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic void set_idling(input int mode);
    case (mode)
      1: begin gap_pct = 61; stall_pct = 0; end
      2: begin gap_pct = 0; stall_pct = 61; end
      3: begin gap_pct = 13; stall_pct = 13; end
      default: begin gap_pct = 0; stall_pct = 0; end
    endcase
  endfunction

  // idle phase: silent samples, ignored note off and unused opcode, slow attack start
  task automatic test_idle_requests();
    send_req(OP_SAMPLE, 16'h7FFF);
    send_req(OP_SAMPLE, 16'h8000);
    send_req(OP_NOTE_OFF, 16'h1234);
    send_req(OP_UNUSED, 16'hFFFF);
    send_req(OP_NOTE_ON, 16'h0000);
    send_req(OP_SAMPLE, 16'h7FFF);
    send_req(OP_SAMPLE, 16'h8000);
  endtask

  // full-scale attack, clamp into decay, sustain floor, release down to idle
  task automatic test_fast_envelope();
    wait_drained();
    program_regs(regs_of(65536, 20000, 40000, 1, 65536));
    send_req(OP_NOTE_ON, 16'hAAAA);
    send_req(OP_SAMPLE, 16'h7FFF);
    send_req(OP_SAMPLE, 16'h8000);
    send_req(OP_SAMPLE, 16'hFFFF);
    send_req(OP_SAMPLE, 16'h5555);
  endtask

  // zero steps skip phases, sustain level above full scale acts as full scale
  task automatic test_zero_steps();
    wait_drained();
    program_regs(regs_of(0, 0, 131071, 2, 0));
    send_req(OP_NOTE_ON, 16'h0000);
    send_req(OP_SAMPLE, 16'h3039);
    send_req(OP_SAMPLE, 16'hFFF9);
    send_req(OP_SAMPLE, 16'h7FFF);
    send_req(OP_NOTE_ON, 16'hFFFF);
    send_req(OP_NOTE_OFF, 16'h0000);
    send_req(OP_SAMPLE, 16'h8000);
  endtask

  // sustain count left above a lowered sustain length ends sustain at once
  task automatic test_sustain_bound();
    wait_drained();
    program_regs(regs_of(65536, 65536, 0, 16777215, 1));
    send_req(OP_NOTE_ON, 16'h0F0F);
    send_req(OP_SAMPLE, 16'h7FFF);
    send_req(OP_SAMPLE, 16'h8000);
    send_req(OP_SAMPLE, 16'h4000);
    send_req(OP_SAMPLE, 16'hC000);
    wait_drained();
    program_regs(regs_of(65536, 65536, 0, 1, 1));
    send_req(OP_SAMPLE, 16'h7FFF);
  endtask

  // mostly whole notes with random content, some stray requests
  task automatic test_random_notes(input int quota);
    int         sent;
    int         len;
    int         n;
    logic [1:0] op;
    wait_drained();
    program_regs(rand_regs());
    sent = 0;
    while (sent < quota) begin
      if ($urandom_range(99) < 85) begin
        send_req(OP_NOTE_ON, rand_sample());
        len = $urandom_range(1, 12);
        for (n = 0; n < len; n++) send_req(OP_SAMPLE, rand_sample());
        sent += len + 1;
        if ($urandom_range(99) < 70) begin
          send_req(OP_NOTE_OFF, rand_sample());
          sent++;
        end
        len = $urandom_range(0, 10);
        for (n = 0; n < len; n++) send_req(OP_SAMPLE, rand_sample());
        sent += len;
        // occasional full drain in the middle of a run of notes
        if ($urandom_range(19) == 0) wait_drained();
      end else begin
        op = 2'($urandom_range(3));
        send_req(op, rand_sample());
        if (op != OP_UNUSED) sent++;
      end
    end
  endtask

  initial begin : main
    int round;
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = CFG_ATTACK_STEP;
    cfg_wdata = '0;
    in_tvalid = 1'b0;
    in_tuser  = OP_SAMPLE;
    in_tdata  = '0;
    envelope_reset();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_idling(3);
    test_idle_requests();
    test_fast_envelope();
    test_zero_steps();
    test_sustain_bound();
    for (round = 0; round < RANDOM_ROUNDS; round++) begin
      set_idling(round % 4);
      test_random_notes(ROUND_REQUESTS);
    end

    wait_drained();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
sv/adsr_pkg.sv
sv/adsr_cfg.sv
sv/adsr_env.sv
sv/adsr_gain.sv
sv/adsr_envelope_gain.sv
dv/testbench.sv
